// ===== sv/shcdf_pkg.sv =====
`timescale 1ns / 1ps

package shcdf_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    localparam int POS_W = 9;

    // Frame byte positions; from POS_PARAM on, position = POS_PARAM + parameter index
    localparam logic [POS_W-1:0] POS_SYNC1  = 9'd0;
    localparam logic [POS_W-1:0] POS_SYNC2  = 9'd1;
    localparam logic [POS_W-1:0] POS_DEVICE = 9'd2;
    localparam logic [POS_W-1:0] POS_METHOD = 9'd3;
    localparam logic [POS_W-1:0] POS_LENGTH = 9'd4;
    localparam logic [POS_W-1:0] POS_PARAM  = 9'd5;
    localparam logic [POS_W-1:0] POS_LAST   = 9'd260;

    typedef enum logic [1:0] {
        KIND_PARAM   = 2'd0,
        KIND_SUM_OK  = 2'd1,
        KIND_SUM_BAD = 2'd2
    } result_kind_t;

    typedef struct packed {
        logic [7:0]   param_value;
        logic [7:0]   param_index;
        logic [7:0]   param_length;
        logic [7:0]   cmd_code;
        logic [7:0]   node_id;
        result_kind_t result_kind;
    } result_t;

endpackage

// ===== sv/sync_header_checksum_deframer_core.sv =====
`timescale 1ns / 1ps

// Frame parser for a byte stream of the form 0x55, 0xAA, device id, method, length,
// <length> parameter bytes, checksum. Takes one word per cycle while no skid word is
// held: the frame position, header fields and 8-bit running sum update in the cycle a
// byte is accepted, and any result lands in an output register backed by one skid
// stage, so input keeps flowing while one result waits and stalls only once a second
// result is held. Results are registered, via the skid stage when the output stalls.
// Each parameter byte comes out with kind 0 and its index; the checksum byte comes out as
// kind 1 (sum good) or kind 2 (sum bad) with index and value zero. Sync and header bytes
// give no result; a bad sync byte drops back to hunting for 0x55 without retesting it.
module sync_header_checksum_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] node_id, [15:8] cmd_code,
                                        // [23:16] param_length, [31:24] param_index,
                                        // [39:32] param_value
    output logic [1:0]  m_axis_tuser    // [1:0] result_kind
);

    logic [shcdf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0] dev_reg, dev_next;
    logic [7:0] meth_reg, meth_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] sum_reg, sum_next;

    shcdf_pkg::result_t out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    shcdf_pkg::result_t skid_reg, skid_next;
    logic               skid_valid_reg, skid_valid_next;

    logic                        in_fire;
    logic                        res_valid;
    shcdf_pkg::result_t          res;
    logic [shcdf_pkg::POS_W-1:0] idx;
    logic [7:0]                  b;
    logic [7:0]                  sum_add;
    logic                        out_free;

    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign sum_add       = sum_reg + b;
    assign idx           = pos_reg - shcdf_pkg::POS_PARAM;

    always_comb
    begin
        pos_next  = pos_reg;
        dev_next  = dev_reg;
        meth_next = meth_reg;
        len_next  = len_reg;
        sum_next  = sum_reg;
        res_valid = 1'b0;
        res.result_kind  = shcdf_pkg::KIND_PARAM;
        res.node_id      = dev_reg;
        res.cmd_code     = meth_reg;
        res.param_length = len_reg;
        res.param_index  = 8'd0;
        res.param_value  = 8'd0;
        if (in_fire)
        begin
            case (pos_reg)
                shcdf_pkg::POS_SYNC1:
                begin
                    if (b == shcdf_pkg::SYNC_FIRST)
                    begin
                        sum_next = shcdf_pkg::SYNC_FIRST;
                        pos_next = shcdf_pkg::POS_SYNC2;
                    end
                end
                shcdf_pkg::POS_SYNC2:
                begin
                    if (b == shcdf_pkg::SYNC_SECOND)
                    begin
                        sum_next = sum_add;
                        pos_next = shcdf_pkg::POS_DEVICE;
                    end
                    else
                    begin
                        pos_next = shcdf_pkg::POS_SYNC1;
                    end
                end
                shcdf_pkg::POS_DEVICE:
                begin
                    dev_next = b;
                    sum_next = sum_add;
                    pos_next = shcdf_pkg::POS_METHOD;
                end
                shcdf_pkg::POS_METHOD:
                begin
                    meth_next = b;
                    sum_next  = sum_add;
                    pos_next  = shcdf_pkg::POS_LENGTH;
                end
                shcdf_pkg::POS_LENGTH:
                begin
                    len_next = b;
                    sum_next = sum_add;
                    pos_next = shcdf_pkg::POS_PARAM;
                end
                default:
                begin
                    res_valid = 1'b1;
                    if (idx < {1'b0, len_reg})
                    begin
                        res.param_index = idx[7:0];
                        res.param_value = b;
                        sum_next = sum_add;
                        pos_next = pos_reg + 9'd1;
                    end
                    else
                    begin
                        res.result_kind = (sum_reg == b) ? shcdf_pkg::KIND_SUM_OK
                                                         : shcdf_pkg::KIND_SUM_BAD;
                        pos_next = shcdf_pkg::POS_SYNC1;
                    end
                end
            endcase
        end
    end

    // output register with one skid word behind it
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= shcdf_pkg::POS_SYNC1;
            dev_reg        <= 8'd0;
            meth_reg       <= 8'd0;
            len_reg        <= 8'd0;
            sum_reg        <= 8'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            dev_reg        <= dev_next;
            meth_reg       <= meth_next;
            len_reg        <= len_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.result_kind;
    assign m_axis_tdata  = {out_reg.param_value, out_reg.param_index, out_reg.param_length,
                            out_reg.cmd_code, out_reg.node_id};

`ifndef SYNTHESIS
    // a held skid word implies the output register is occupied
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= shcdf_pkg::POS_LAST)
        else $error("frame position out of range");

    // checksum results carry zero index and value
    a_sum_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != shcdf_pkg::KIND_PARAM)
            |-> (m_axis_tdata[39:24] == 16'd0))
        else $error("checksum result with nonzero index or value");

    // a parameter word's index stays below the declared length
    a_param_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == shcdf_pkg::KIND_PARAM)
            |-> (m_axis_tdata[31:24] < m_axis_tdata[23:16]))
        else $error("parameter index beyond frame length");
`endif

endmodule

// ===== tb/sync_header_checksum_deframer_core_tb.sv =====
`timescale 1ns / 1ps

module sync_header_checksum_deframer_core_tb;

    localparam int TOTAL_ITEMS = 1550;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIR       = 26;

    // one directed word; when typed is set the expected word is given inline
    typedef struct packed {
        logic [7:0]              data;
        logic                    typed;
        shcdf_pkg::result_kind_t kind;
        logic [7:0]              dev;
        logic [7:0]              meth;
        logic [7:0]              len;
        logic [7:0]              idx;
        logic [7:0]              val;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // bad second sync byte
        '{8'h55, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        // zero length frame, good checksum
        '{8'h55, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hAA, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFE, 1'b1, shcdf_pkg::KIND_SUM_OK,  8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
        // two params, bad checksum
        '{8'h55, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hAA, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 1'b1, shcdf_pkg::KIND_PARAM,   8'h00, 8'hFF, 8'h02, 8'h00, 8'h00},
        '{8'hFF, 1'b1, shcdf_pkg::KIND_PARAM,   8'h00, 8'hFF, 8'h02, 8'h01, 8'hFF},
        '{8'h00, 1'b1, shcdf_pkg::KIND_SUM_BAD, 8'h00, 8'hFF, 8'h02, 8'h00, 8'h00},
        // 0x55 in second sync slot is dropped, then 0xAA at hunt is ignored
        '{8'h55, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h55, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hAA, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        // one param, checked by the predictor
        '{8'h55, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hAA, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h3C, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hC3, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h80, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h7F, 1'b0, shcdf_pkg::KIND_PARAM,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // predictor state
    logic [shcdf_pkg::POS_W-1:0] frame_pos = shcdf_pkg::POS_SYNC1;
    logic [7:0]                  hold_dev = 8'h00;
    logic [7:0]                  hold_method = 8'h00;
    logic [7:0]                  hold_len = 8'h00;
    logic [7:0]                  frame_sum = 8'h00;

    shcdf_pkg::result_t expected_words [$];
    int      errors = 0;
    int      cycles = 0;
    int      items_sent = 0;
    int      n_params = 0;
    int      n_sum_ok = 0;
    int      n_sum_bad = 0;
    int      n_long = 0;
    int      ready_hold = 0;
    logic    calm = 1'b0;

    sync_header_checksum_deframer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // advances the frame parser by one byte, returns the word it emits if any
    task automatic deframe_byte(input logic [7:0] b, output logic got,
                                output shcdf_pkg::result_t res);
        logic [shcdf_pkg::POS_W-1:0] idx;
        got = 1'b0;
        res = '0;
        case (frame_pos)
            shcdf_pkg::POS_SYNC1:
                if (b == shcdf_pkg::SYNC_FIRST)
                begin
                    frame_sum = shcdf_pkg::SYNC_FIRST;
                    frame_pos = shcdf_pkg::POS_SYNC2;
                end
            shcdf_pkg::POS_SYNC2:
                if (b == shcdf_pkg::SYNC_SECOND)
                begin
                    frame_sum = frame_sum + b;
                    frame_pos = shcdf_pkg::POS_DEVICE;
                end
                else
                    frame_pos = shcdf_pkg::POS_SYNC1;
            shcdf_pkg::POS_DEVICE:
            begin
                hold_dev = b;
                frame_sum = frame_sum + b;
                frame_pos = shcdf_pkg::POS_METHOD;
            end
            shcdf_pkg::POS_METHOD:
            begin
                hold_method = b;
                frame_sum = frame_sum + b;
                frame_pos = shcdf_pkg::POS_LENGTH;
            end
            shcdf_pkg::POS_LENGTH:
            begin
                hold_len = b;
                frame_sum = frame_sum + b;
                frame_pos = shcdf_pkg::POS_PARAM;
            end
            default:
            begin
                idx = frame_pos - shcdf_pkg::POS_PARAM;
                got = 1'b1;
                res.node_id = hold_dev;
                res.cmd_code = hold_method;
                res.param_length = hold_len;
                if (idx < {1'b0, hold_len})
                begin
                    res.result_kind = shcdf_pkg::KIND_PARAM;
                    res.param_index = idx[7:0];
                    res.param_value = b;
                    frame_sum = frame_sum + b;
                    frame_pos = frame_pos + 1'b1;
                    n_params++;
                end
                else
                begin
                    res.result_kind = (frame_sum == b) ? shcdf_pkg::KIND_SUM_OK
                                                       : shcdf_pkg::KIND_SUM_BAD;
                    if (frame_sum == b)
                        n_sum_ok++;
                    else
                        n_sum_bad++;
                    frame_pos = shcdf_pkg::POS_SYNC1;
                end
            end
        endcase
    endtask

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input shcdf_pkg::result_t typed_res);
        int                 gap;
        logic               got;
        shcdf_pkg::result_t res;
        gap = idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        deframe_byte(b, got, res);
        if (typed)
            expected_words.push_back(typed_res);
        else if (got)
            expected_words.push_back(res);
    endtask

    task automatic drain_pause();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
    endtask

    task automatic send_frame();
        int         len;
        int         r;
        logic [7:0] sum_byte;
        r = $urandom_range(0, 99);
        if (r < 2 && n_long < 2)
        begin
            len = 255;
            n_long++;
        end
        else if (r < 12)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(0, 8);
        send_byte(shcdf_pkg::SYNC_FIRST, 1'b0, '0);
        send_byte(shcdf_pkg::SYNC_SECOND, 1'b0, '0);
        send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        send_byte(len[7:0], 1'b0, '0);
        repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        sum_byte = frame_sum;
        if ($urandom_range(0, 99) < 15)
            sum_byte = sum_byte ^ 8'($urandom_range(1, 255));
        send_byte(sum_byte, 1'b0, '0);
    endtask

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // output side: check accepted words, then pick next tready
    always @(posedge clk)
    begin
        shcdf_pkg::result_t exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected output word: tuser %0h tdata %0h",
                       m_axis_tuser, m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                check_field("result_kind", 8'(exp_w.result_kind), 8'(m_axis_tuser));
                check_field("node_id", exp_w.node_id, m_axis_tdata[7:0]);
                check_field("cmd_code", exp_w.cmd_code, m_axis_tdata[15:8]);
                check_field("param_length", exp_w.param_length, m_axis_tdata[23:16]);
                check_field("param_index", exp_w.param_index, m_axis_tdata[31:24]);
                check_field("param_value", exp_w.param_value, m_axis_tdata[39:32]);
            end
        end
        if (ready_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            ready_hold--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            ready_hold = idle_len();
        end
    end

    initial
    begin
        shcdf_pkg::result_t typed_res;
        int                 r;
        int                 n;
        logic [7:0]         b;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            typed_res = '0;
            typed_res.result_kind = DIR_ROWS[i].kind;
            typed_res.node_id = DIR_ROWS[i].dev;
            typed_res.cmd_code = DIR_ROWS[i].meth;
            typed_res.param_length = DIR_ROWS[i].len;
            typed_res.param_index = DIR_ROWS[i].idx;
            typed_res.param_value = DIR_ROWS[i].val;
            send_byte(DIR_ROWS[i].data, DIR_ROWS[i].typed, typed_res);
        end
        drain_pause();

        while (items_sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                calm = ~calm;
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                // line noise
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end
            else if (r < 14)
            begin
                // broken sync pair
                send_byte(shcdf_pkg::SYNC_FIRST, 1'b0, '0);
                do b = 8'($urandom_range(0, 255)); while (b == shcdf_pkg::SYNC_SECOND);
                send_byte(b, 1'b0, '0);
            end
            else
                send_frame();
            if ($urandom_range(0, 99) < 3)
                drain_pause();
        end

        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes: %0d param words, %0d good and %0d bad checksums,",
                 items_sent, n_params, n_sum_ok, n_sum_bad);
        $display("%0d long frames, with noise, broken syncs and stalls on both sides.",
                 n_long);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
